### rtl/core/tibd_pkg.sv
// tibd_pkg: shared types and constants of the tape image block deframer
// holds the request and result structs, kind codes, flag bits and parser state type
// no dependencies
package tibd_pkg;

    localparam int LEN_BITS   = 24;
    localparam int BLK_BITS   = 16;
    localparam int SOFAR_BITS = LEN_BITS + 1;

    localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = LEN_BITS'(65535);

    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_EMPTY_END = 2'd1;
    localparam logic [1:0] KIND_TAPEMARK  = 2'd2;
    localparam logic [1:0] KIND_ERROR     = 2'd3;

    // bit positions within flags1
    localparam int FLAG_START_BIT  = 7;
    localparam int FLAG_TMARK_BIT  = 6;
    localparam int FLAG_ENDREC_BIT = 5;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } tibd_in_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          payload_byte;
        logic                record_last;
        logic [LEN_BITS-1:0] record_length;
    } tibd_out_t;

    typedef struct packed {
        logic [2:0]            hdr_pos;
        logic [BLK_BITS-1:0]   blk_len;
        logic [7:0]            blk_flags;
        logic                  in_record;
        logic                  in_payload;
        logic [BLK_BITS-1:0]   left;
        logic [SOFAR_BITS-1:0] sofar;
    } tibd_state_t;

    localparam tibd_state_t STATE_CLEAR = '0;

    typedef struct packed {
        logic      has_result;
        tibd_out_t result;
    } tibd_step_t;

endpackage

### rtl/core/tibd_in_reg.sv
// tibd_in_reg: input register stage of the deframer
// captures one request and holds it until the parser advances; uses tibd_pkg
module tibd_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tibd_pkg::tibd_in_t s_data,
    input  logic              advance,
    output logic              in_valid,
    output tibd_pkg::tibd_in_t in_data
);
    import tibd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    tibd_in_t data_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign in_valid = valid_reg;
    assign in_data  = data_reg;

endmodule

### rtl/core/tibd_parser.sv
// tibd_parser: header collection, payload counting and record checks
// holds the record state and forms at most one result per request; uses tibd_pkg
module tibd_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tibd_pkg::tibd_in_t            in_data,
    input  logic                          advance,
    input  logic [tibd_pkg::LEN_BITS-1:0] max_len,
    output tibd_pkg::tibd_step_t          step
);
    import tibd_pkg::*;

    localparam logic [2:0] HDR_LEN_LO = 3'd0;
    localparam logic [2:0] HDR_LEN_HI = 3'd1;
    localparam logic [2:0] HDR_FLAGS1 = 3'd4;
    localparam logic [2:0] HDR_LAST   = 3'd5;

    tibd_state_t st_reg;
    tibd_state_t st_next;

    logic [BLK_BITS-1:0]   left_dec;
    logic [SOFAR_BITS-1:0] sum;
    logic                  len_zero;
    logic                  f_start;
    logic                  f_tmark;
    logic                  f_endrec;

    assign left_dec = st_reg.left - BLK_BITS'(1);
    assign sum      = st_reg.sofar + SOFAR_BITS'(st_reg.blk_len);
    assign len_zero = (st_reg.blk_len == '0);
    assign f_start  = st_reg.blk_flags[FLAG_START_BIT];
    assign f_tmark  = st_reg.blk_flags[FLAG_TMARK_BIT];
    assign f_endrec = st_reg.blk_flags[FLAG_ENDREC_BIT];

    always_comb begin
        st_next         = st_reg;
        step            = '0;
        step.has_result = 1'b0;
        if (in_data.end_of_stream) begin
            st_next          = STATE_CLEAR;
            step.has_result  = 1'b1;
            step.result.kind = KIND_ERROR;
        end else if (st_reg.in_payload) begin
            st_next.left             = left_dec;
            step.has_result          = 1'b1;
            step.result.kind         = KIND_DATA;
            step.result.payload_byte = in_data.stream_byte;
            if (left_dec == '0) begin
                st_next.in_payload = 1'b0;
                if (f_endrec) begin
                    st_next                   = STATE_CLEAR;
                    step.result.record_last   = 1'b1;
                    step.result.record_length = st_reg.sofar[LEN_BITS-1:0];
                end
            end
        end else begin
            st_next.hdr_pos = st_reg.hdr_pos + 3'd1;
            unique case (st_reg.hdr_pos)
                HDR_LEN_LO: begin
                    st_next.blk_len = {8'h00, in_data.stream_byte};
                end
                HDR_LEN_HI: begin
                    st_next.blk_len = {in_data.stream_byte, st_reg.blk_len[7:0]};
                end
                HDR_FLAGS1: begin
                    st_next.blk_flags = in_data.stream_byte;
                end
                HDR_LAST: begin
                    st_next.hdr_pos = '0;
                    if (!st_reg.in_record && len_zero && f_tmark) begin
                        st_next          = STATE_CLEAR;
                        step.has_result  = 1'b1;
                        step.result.kind = KIND_TAPEMARK;
                    end else if ((!st_reg.in_record && !f_start) || f_tmark
                                 || (sum > SOFAR_BITS'(max_len))) begin
                        st_next          = STATE_CLEAR;
                        step.has_result  = 1'b1;
                        step.result.kind = KIND_ERROR;
                    end else begin
                        st_next.in_record = 1'b1;
                        st_next.sofar     = sum;
                        if (!len_zero) begin
                            st_next.in_payload = 1'b1;
                            st_next.left       = st_reg.blk_len;
                        end else if (f_endrec) begin
                            // empty final block closes the record
                            st_next                   = STATE_CLEAR;
                            step.has_result           = 1'b1;
                            step.result.kind          = KIND_EMPTY_END;
                            step.result.record_last   = 1'b1;
                            step.result.record_length = sum[LEN_BITS-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= STATE_CLEAR;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

endmodule

### rtl/core/tibd_out_reg.sv
// tibd_out_reg: result register of the deframer
// holds one result until the consumer takes it; uses tibd_pkg
module tibd_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  tibd_pkg::tibd_out_t load_data,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output tibd_pkg::tibd_out_t m_data
);
    import tibd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    tibd_out_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

### rtl/core/tape_image_block_deframer.sv
// tape_image_block_deframer: byte-wide tape image block header parser
// a request is held in the input register, then its result is loaded into the result register
// throughput: one byte per cycle while the result register can take each result; the parser updates its state per byte
// reset: synchronous active low aresetn clears all record state and both valid flags,
// max_len_reg returns to 65535; depends on tibd_pkg, tibd_in_reg, tibd_parser, tibd_out_reg
module tape_image_block_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tibd_pkg::tibd_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tibd_pkg::tibd_out_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tibd_pkg::LEN_BITS-1:0] cfg_data
);
    import tibd_pkg::*;

    logic                in_valid;
    tibd_in_t            in_data;
    logic                advance;
    logic                can_load;
    tibd_step_t          step;
    logic [LEN_BITS-1:0] max_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_valid) begin
            max_len_reg <= cfg_data;
        end
    end

    // a request with no result moves on even while the result register is full
    assign advance = in_valid && (!step.has_result || can_load);

    tibd_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .advance  (advance),
        .in_valid (in_valid),
        .in_data  (in_data)
    );

    tibd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (in_data),
        .advance (advance),
        .max_len (max_len_reg),
        .step    (step)
    );

    tibd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && step.has_result),
        .load_data (step.result),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### rtl/core/tibd_checker.sv
// tibd_checker: port-level assertions for the deframer
// bound to tape_image_block_deframer; uses tibd_pkg
module tibd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input tibd_pkg::tibd_out_t           m_data
);
    import tibd_pkg::*;

    // coming out of reset the block is empty and takes a request
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("block not empty after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    a_byte_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.kind != KIND_DATA)) |-> (m_data.payload_byte == 8'h00))
        else $error("payload byte on non-data result");

    a_len_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.record_last) |-> (m_data.record_length == '0))
        else $error("record length without record end");

    a_no_last_on_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_data.kind == KIND_TAPEMARK) || (m_data.kind == KIND_ERROR)))
        |-> !m_data.record_last)
        else $error("record end on tapemark or error");

endmodule

bind tape_image_block_deframer tibd_checker u_chk (.*);

### verif/tb_tape_image_block_deframer.sv
// tb_tape_image_block_deframer: self-checking bench for the tape image block deframer
// drives tape image bytes with random bursts and output stalls, checks every result
// against an in-bench header parser; depends on tibd_pkg and tape_image_block_deframer
`timescale 1ns / 100ps

module tb_tape_image_block_deframer;
    import tibd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 170;
    localparam int NUM_PHASES = 7;

    typedef enum int {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_PERIODIC
    } ready_mode_e;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    tibd_in_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    tibd_out_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LEN_BITS-1:0] cfg_data = '0;

    tape_image_block_deframer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // parser mirror
    logic [2:0]            hdr_idx = '0;
    logic [BLK_BITS-1:0]   blk_len = '0;
    logic [7:0]            blk_flags = '0;
    logic                  rec_open = 1'b0;
    logic                  in_data = 1'b0;
    logic [BLK_BITS-1:0]   blk_left = '0;
    logic [SOFAR_BITS-1:0] rec_total = '0;
    logic [LEN_BITS-1:0]   max_len = MAX_LEN_RESET;

    tibd_in_t  pending_bytes[$];
    tibd_out_t expected_results[$];
    int        pushed_cnt = 0;
    int        accepted_cnt = 0;
    int        mismatches = 0;
    int        cycles = 0;
    logic      s_acc = 1'b0;
    logic      cfg_acc = 1'b0;
    logic [LEN_BITS-1:0] gen_max = MAX_LEN_RESET;

    task automatic clear_record();
        hdr_idx = '0;
        blk_len = '0;
        blk_flags = '0;
        rec_open = 1'b0;
        in_data = 1'b0;
        blk_left = '0;
        rec_total = '0;
    endtask

    task automatic deframe_byte(input tibd_in_t req, output bit has, output tibd_out_t res);
        res = '0;
        has = 1'b0;
        if (req.end_of_stream) begin
            clear_record();
            res.kind = KIND_ERROR;
            has = 1'b1;
            return;
        end
        if (in_data) begin
            blk_left = blk_left - 1'b1;
            res.kind = KIND_DATA;
            res.payload_byte = req.stream_byte;
            has = 1'b1;
            if (blk_left == '0) begin
                in_data = 1'b0;
                if (blk_flags[FLAG_ENDREC_BIT]) begin
                    res.record_last = 1'b1;
                    res.record_length = rec_total[LEN_BITS-1:0];
                    clear_record();
                end
            end
            return;
        end
        if (hdr_idx != 3'd5) begin
            case (hdr_idx)
                3'd0: blk_len = {8'h00, req.stream_byte};
                3'd1: blk_len[15:8] = req.stream_byte;
                3'd4: blk_flags = req.stream_byte;
                default: ;
            endcase
            hdr_idx = hdr_idx + 3'd1;
            return;
        end
        // last header byte: decide what the block means
        hdr_idx = '0;
        has = 1'b1;
        if (!rec_open && blk_len == '0 && blk_flags[FLAG_TMARK_BIT]) begin
            clear_record();
            res.kind = KIND_TAPEMARK;
        end else if ((!rec_open && !blk_flags[FLAG_START_BIT]) || blk_flags[FLAG_TMARK_BIT]) begin
            clear_record();
            res.kind = KIND_ERROR;
        end else begin
            rec_total = rec_total + SOFAR_BITS'(blk_len);
            if (rec_total > SOFAR_BITS'(max_len)) begin
                clear_record();
                res.kind = KIND_ERROR;
            end else begin
                rec_open = 1'b1;
                if (blk_len == '0) begin
                    if (blk_flags[FLAG_ENDREC_BIT]) begin
                        res.kind = KIND_EMPTY_END;
                        res.record_last = 1'b1;
                        res.record_length = rec_total[LEN_BITS-1:0];
                        clear_record();
                    end else begin
                        has = 1'b0;
                    end
                end else begin
                    in_data = 1'b1;
                    blk_left = blk_len;
                    has = 1'b0;
                end
            end
        end
    endtask

    // request and result monitor
    always @(posedge aclk) begin
        tibd_out_t exp_res;
        tibd_out_t pred;
        bit        has;
        cycles = cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        s_acc = aresetn && s_valid && s_ready;
        cfg_acc = aresetn && cfg_valid && cfg_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result: kind=%0d byte=%02h last=%0b len=%0d",
                             m_data.kind, m_data.payload_byte, m_data.record_last,
                             m_data.record_length);
            end else begin
                exp_res = expected_results.pop_front();
                if (m_data.kind !== exp_res.kind ||
                    m_data.payload_byte !== exp_res.payload_byte ||
                    m_data.record_last !== exp_res.record_last ||
                    m_data.record_length !== exp_res.record_length) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind=%0d byte=%02h last=%0b len=%0d, %s",
                                 exp_res.kind, exp_res.payload_byte, exp_res.record_last,
                                 exp_res.record_length,
                                 $sformatf("got kind=%0d byte=%02h last=%0b len=%0d",
                                           m_data.kind, m_data.payload_byte,
                                           m_data.record_last, m_data.record_length));
                end
            end
        end
        if (s_acc) begin
            accepted_cnt = accepted_cnt + 1;
            deframe_byte(s_data, has, pred);
            if (has)
                expected_results.push_back(pred);
        end
        if (cfg_acc)
            max_len = cfg_data;
    end

    // request driver: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_acc) begin
            if (burst_left == 0 && gap_left == 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    burst_left = $urandom_range(64, 256);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = $urandom_range(0, 8);
                end
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                s_data <= pending_bytes.pop_front();
                s_valid <= 1'b1;
                burst_left = burst_left - 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result stall pattern
    ready_mode_e rdy_mode = RDY_ALWAYS;
    int          mode_left = 0;
    int          period_cnt = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rdy_mode = ready_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left = mode_left - 1;
            period_cnt = (period_cnt + 1) % 5;
            case (rdy_mode)
                RDY_ALWAYS:   m_ready <= 1'b1;
                RDY_HALF:     m_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                default:      m_ready <= (period_cnt < 2);
            endcase
        end
    end

    task automatic push_byte(input logic [7:0] b);
        tibd_in_t req;
        req.stream_byte = b;
        req.end_of_stream = 1'b0;
        pending_bytes.push_back(req);
        pushed_cnt = pushed_cnt + 1;
    endtask

    task automatic push_eos();
        tibd_in_t req;
        req.stream_byte = 8'($urandom_range(0, 255));
        req.end_of_stream = 1'b1;
        pending_bytes.push_back(req);
        pushed_cnt = pushed_cnt + 1;
    endtask

    task automatic push_header(input logic [15:0] len, input logic [15:0] prev,
                               input logic [7:0] f1, input logic [7:0] f2);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        push_byte(prev[7:0]);
        push_byte(prev[15:8]);
        push_byte(f1);
        push_byte(f2);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 8);
        else if (r < 98)
            return $urandom_range(9, 40);
        else
            return $urandom_range(200, 300);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // well-formed record of one to three blocks; stops early where the length check trips
    task automatic gen_record();
        int                    nblk;
        int                    blen;
        logic [SOFAR_BITS-1:0] sum;
        logic [7:0]            f1;
        nblk = $urandom_range(1, 3);
        sum = '0;
        for (int i = 0; i < nblk; i++) begin
            blen = pick_len();
            f1 = rand_byte();
            f1[FLAG_TMARK_BIT] = 1'b0;
            if (i == 0)
                f1[FLAG_START_BIT] = 1'b1;
            f1[FLAG_ENDREC_BIT] = (i == nblk - 1);
            push_header(16'(blen), 16'($urandom_range(0, 65535)), f1, rand_byte());
            sum = sum + SOFAR_BITS'(blen);
            if (sum > SOFAR_BITS'(gen_max))
                return;
            for (int k = 0; k < blen; k++)
                push_byte(rand_byte());
        end
    endtask

    task automatic gen_sequence();
        int         sel;
        int         blen;
        int         n;
        logic [7:0] f1;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            gen_record();
        end else if (sel < 80) begin
            f1 = rand_byte();
            f1[FLAG_TMARK_BIT] = 1'b1;
            push_header(16'd0, 16'($urandom_range(0, 65535)), f1, rand_byte());
        end else if (sel < 85) begin
            // first header without start flag
            f1 = rand_byte();
            f1[FLAG_START_BIT] = 1'b0;
            f1[FLAG_TMARK_BIT] = 1'b0;
            push_header(16'($urandom_range(0, 8)), 16'($urandom_range(0, 65535)), f1,
                        rand_byte());
        end else if (sel < 90) begin
            // tapemark flag on a data block or on a continuation
            f1 = rand_byte();
            f1[FLAG_START_BIT] = 1'b1;
            f1[FLAG_TMARK_BIT] = 1'b1;
            if ($urandom_range(0, 1) == 0) begin
                push_header(16'($urandom_range(1, 8)), 16'($urandom_range(0, 65535)), f1,
                            rand_byte());
            end else begin
                blen = $urandom_range(0, 4);
                push_header(16'(blen), 16'd0, 8'h80, rand_byte());
                if (blen <= gen_max) begin
                    for (int k = 0; k < blen; k++)
                        push_byte(rand_byte());
                    push_header(16'd0, 16'($urandom_range(0, 65535)), f1, rand_byte());
                end
            end
        end else if (sel < 95) begin
            // random bytes cut short by end of stream
            n = $urandom_range(0, 9);
            for (int k = 0; k < n; k++)
                push_byte(rand_byte());
            push_eos();
        end else begin
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
                push_byte(rand_byte());
            push_eos();
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (accepted_cnt != pushed_cnt || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_max_len(input logic [LEN_BITS-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(negedge aclk);
        while (!cfg_acc);
        cfg_valid <= 1'b0;
        gen_max = value;
    endtask

    initial begin
        int                  phase_start;
        logic [LEN_BITS-1:0] phase_max;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // directed requests
        push_header(16'd0, 16'hFFFF, 8'h40, 8'hFF);
        push_header(16'd0, 16'd0, 8'hA0, 8'h00);
        push_header(16'd0, 16'hFFFF, 8'h1F, 8'hFF);
        push_header(16'd1, 16'd0, 8'hC0, 8'h00);
        push_eos();
        push_header(16'd1, 16'd0, 8'hA0, 8'h00);
        push_byte(8'hFF);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: phase_max = '0;
                    2: phase_max = '1;
                    3: phase_max = LEN_BITS'($urandom_range(1, 24));
                    4: phase_max = LEN_BITS'($urandom_range(0, 16777215));
                    5: phase_max = LEN_BITS'(12);
                    default: phase_max = MAX_LEN_RESET;
                endcase
                write_max_len(phase_max);
            end
            phase_start = pushed_cnt;
            while (pushed_cnt - phase_start < PHASE_ITEMS)
                gen_sequence();
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
